// ===== design/rmn_pkg.sv =====
// Shared types for the running median unit.
// No dependencies; used by the queue, the front, the back and the top level.
package rmn_pkg;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   localparam int QUEUE_DEPTH = 2;

endpackage

// ===== design/rmn_fifo.sv =====
// Small first-in first-out queue of registers with a packed status output.
// Depends on rmn_pkg for the status type and the default depth.
module rmn_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = rmn_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         rd_data,
   output rmn_pkg::fifo_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/rmn_front.sv =====
// Input side of the running median unit: takes samples and tags each with its ring slot.
// Depends on rmn_pkg for the queue status type.
module rmn_front #(
   parameter int WINDOW_LEN  = 9,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  rmn_pkg::fifo_status_type      queue_status,
   output logic                          queue_push,
   output logic [SAMPLE_BITS-1:0]        queue_sample,
   output logic [$clog2(WINDOW_LEN)-1:0] queue_slot
);

   localparam int SLOT_BITS = $clog2(WINDOW_LEN);

   logic [SLOT_BITS-1:0] slot_ff, slot_in;

   assign queue_push   = push && !queue_status.full;
   assign queue_sample = sample;
   assign queue_slot   = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (queue_push) begin
         slot_in = (slot_ff >= SLOT_BITS'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== design/rmn_back.sv =====
// Window store and rank-based median selection of the running median unit.
// Depends on rmn_pkg for the queue status type.
module rmn_back #(
   parameter int WINDOW_LEN  = 9,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rmn_pkg::fifo_status_type      in_status,
   input  logic [SAMPLE_BITS-1:0]        in_sample,
   input  logic [$clog2(WINDOW_LEN)-1:0] in_slot,
   output logic                          in_pop,
   input  rmn_pkg::fifo_status_type      out_status,
   output logic                          out_push,
   output logic [SAMPLE_BITS-1:0]        out_median
);

   localparam int RANK_BITS = $clog2(WINDOW_LEN);
   localparam int MID_POS   = WINDOW_LEN / 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_COUNT,
      ST_PICK
   } state_type;

   state_type                   state_ff;
   logic signed [SAMPLE_BITS-1:0] window_ff [WINDOW_LEN];
   logic [WINDOW_LEN-1:0]       before_ff [WINDOW_LEN];
   logic [WINDOW_LEN-1:0]       before_in [WINDOW_LEN];
   logic [WINDOW_LEN-1:0]       hit_ff, hit_in;
   logic [RANK_BITS-1:0]        rank [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0]      pick;

   assign in_pop     = (state_ff == ST_IDLE) && !in_status.empty && !out_status.full;
   assign out_push   = (state_ff == ST_PICK);
   assign out_median = pick;

   // An entry ranks ahead of another when it is smaller, or equal and stored at a lower slot.
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         for (int j = 0; j < WINDOW_LEN; j++) begin
            before_in[i][j] = (window_ff[j] < window_ff[i]) ||
                              ((j < i) && (window_ff[j] == window_ff[i]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            rank[i] = rank[i] + RANK_BITS'(before_ff[i][j]);
         end
         hit_in[i] = (rank[i] == RANK_BITS'(MID_POS));
      end
   end

   always_comb begin
      pick = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         pick = pick | (window_ff[i] & {SAMPLE_BITS{hit_ff[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_pop) begin
                  window_ff[in_slot] <= in_sample;
                  state_ff           <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_COUNT;
            end
            ST_COUNT: begin
               state_ff <= ST_PICK;
            end
            ST_PICK: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         before_ff <= before_in;
      end
      if (state_ff == ST_COUNT) begin
         hit_ff <= hit_in;
      end
   end

endmodule

// ===== design/running_median_nine_unit.sv =====
// Channel   Ports                          Direction
// request   push, full, req_sample         in
// response  pop, empty, rsp_median         out
//
// Each item passes through the back end in order: window write, pairwise compare,
// rank count, median select. The back end takes no new item until it has finished
// the last one; queues on both sides absorb bursts and stalls independently.
// Synchronous reset clears the window to zero, the ring slot and both queues.
// Results that are not popped stall the back end only once the result queue is full.
module running_median_nine_unit #(
   parameter int WINDOW_LEN  = 9,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          empty,
   input  logic                          pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_median
);

   localparam int SLOT_BITS = $clog2(WINDOW_LEN);

   rmn_pkg::fifo_status_type req_status, rsp_status;
   logic                      q_push, q_pop, r_push;
   logic [SAMPLE_BITS-1:0]    q_sample, b_sample, r_median, r_rd;
   logic [SLOT_BITS-1:0]      q_slot, b_slot;

   assign full       = req_status.full;
   assign empty      = rsp_status.empty;
   assign rsp_median = r_rd;

   rmn_front #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .sample       (req_sample),
      .queue_status (req_status),
      .queue_push   (q_push),
      .queue_sample (q_sample),
      .queue_slot   (q_slot)
   );

   rmn_fifo #(.WIDTH(SAMPLE_BITS + SLOT_BITS)) u_work_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data ({q_sample, q_slot}),
      .pop     (q_pop),
      .rd_data ({b_sample, b_slot}),
      .status  (req_status)
   );

   rmn_back #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_status  (req_status),
      .in_sample  (b_sample),
      .in_slot    (b_slot),
      .in_pop     (q_pop),
      .out_status (rsp_status),
      .out_push   (r_push),
      .out_median (r_median)
   );

   rmn_fifo #(.WIDTH(SAMPLE_BITS)) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (r_push),
      .wr_data (r_median),
      .pop     (pop),
      .rd_data (r_rd),
      .status  (rsp_status)
   );

endmodule
